[rtl/core/audio_container_signature_sniffer_defines.svh]
// Assertion macros shared by the checker of the container signature sniffer.
`ifndef AUDIO_CONTAINER_SIGNATURE_SNIFFER_DEFINES_SVH
`define AUDIO_CONTAINER_SIGNATURE_SNIFFER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define ACSS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define ACSS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/acss_pkg.sv]
// Types, signature patterns and result codes of the container signature sniffer.
package acss_pkg;

	localparam int POSITION_BITS = 32;

	typedef logic [POSITION_BITS-1:0] pos_t;

	localparam pos_t POS_MAX   = '1;
	localparam int   SCAN_FROM = 28;

	// Patterns are held with their final byte in the low bits, matching the window.
	localparam logic [31:0] PAT_RIFF   = "RIFF";
	localparam logic [31:0] PAT_WAVE   = "WAVE";
	localparam logic [31:0] PAT_FLAC   = "fLaC";
	localparam logic [23:0] PAT_ID3    = "ID3";
	localparam logic [31:0] PAT_OGGS   = "OggS";
	localparam logic [55:0] PAT_VORBIS = {8'h01, "vorbis"};
	localparam logic [63:0] PAT_OPUS   = "OpusHead";
	localparam logic [55:0] PAT_THEORA = {8'h80, "theora"};
	localparam logic [39:0] PAT_OFLAC  = {8'h7F, "FLAC"};
	localparam logic [63:0] PAT_SPEEX  = "Speex   ";
	localparam logic [7:0]  MP3_SYNC   = 8'hFF;
	localparam logic [7:0]  MP3_MASK   = 8'hE0;

	localparam int HDR_LEN = 12;

	// Lowest offset at which the final byte of each pattern may sit.
	localparam pos_t VORBIS_MIN_POS = pos_t'(SCAN_FROM + 7 - 1);
	localparam pos_t OPUS_MIN_POS   = pos_t'(SCAN_FROM + 8 - 1);
	localparam pos_t THEORA_MIN_POS = pos_t'(SCAN_FROM + 7 - 1);
	localparam pos_t OFLAC_MIN_POS  = pos_t'(SCAN_FROM + 5 - 1);
	localparam pos_t SPEEX_MIN_POS  = pos_t'(SCAN_FROM + 8 - 1);

	typedef enum logic [2:0] {
		FMT_UNKNOWN,
		FMT_WAV,
		FMT_FLAC,
		FMT_MP3,
		FMT_OGG_VORBIS
	} format_t;

	typedef enum logic [2:0] {
		DET_NONE,
		DET_OPUS,
		DET_THEORA,
		DET_OGG_FLAC,
		DET_SPEEX,
		DET_UNRECOGNIZED
	} detail_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [2:0] format_code;
		logic [2:0] ogg_detail;
	} result_t;

endpackage

[rtl/core/audio_container_signature_sniffer.sv]
// Top level of the audio container signature sniffer.
// The blob enters one byte per word on the item channel (valid/ready), starting at
// offset zero; last_byte marks the final byte of a blob. For each blob exactly one
// word leaves on the result channel, carrying format_code and ogg_detail.
// A word is taken into an input register; as it leaves that register the header
// store, the seven-byte window and the codec scan are updated and, for a last byte,
// the classification is loaded into the result register. A last byte thus passes the
// input register and then the result register before its result is valid.
// Throughput is one byte per cycle, save while a last byte waits on a held result;
// the scan and final compare are one pass of logic from input to result register.
// When the receiver stalls, the result register holds its word and bytes that are
// not last still flow; only a last byte waits in the input register, and item_ready
// drops, until the held result is taken.
// Asynchronous reset clears the position counter, the scan state and both valid
// flags; the next byte starts a new blob. After each result the position counter
// and the scan state return to reset values, so blobs follow without a gap.
module audio_container_signature_sniffer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  acss_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output acss_pkg::result_t result
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;

	acss_pkg::pos_t       pos_q;
	logic [7:0]           hdr_q [acss_pkg::HDR_LEN];
	logic [55:0]          win_q;
	logic                 vorbis_q;
	acss_pkg::detail_t    kind_q;
	acss_pkg::pos_t       start_q;
	acss_pkg::result_t    result_q;
	logic                 result_valid_q;

	logic                 advance;
	logic [63:0]          win_next;
	logic [7:0]           hdr_next [acss_pkg::HDR_LEN];
	logic                 opus_hit, theora_hit, oflac_hit, speex_hit;
	logic                 hit_any, take;
	acss_pkg::detail_t    hit_kind, kind_next;
	acss_pkg::pos_t       hit_start, start_next;
	logic                 vorbis_next;
	logic                 late_ok;
	acss_pkg::format_t    fmt_c;
	acss_pkg::detail_t    det_c;

	// A byte leaves the input register unless it is a last byte facing a held result.
	assign advance    = valid_s1 && (!last_s1 || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	assign win_next = {win_q, byte_s1};

	always_comb begin
		for (int i = 0; i < acss_pkg::HDR_LEN; i++) begin
			hdr_next[i] = (pos_q == acss_pkg::pos_t'(i)) ? byte_s1 : hdr_q[i];
		end
	end

	// Codec patterns end in different bytes, so at most one can hit per byte.
	always_comb begin
		opus_hit   = (win_next == acss_pkg::PAT_OPUS) && (pos_q >= acss_pkg::OPUS_MIN_POS);
		theora_hit = (win_next[55:0] == acss_pkg::PAT_THEORA)
			&& (pos_q >= acss_pkg::THEORA_MIN_POS);
		oflac_hit  = (win_next[39:0] == acss_pkg::PAT_OFLAC)
			&& (pos_q >= acss_pkg::OFLAC_MIN_POS);
		speex_hit  = (win_next == acss_pkg::PAT_SPEEX) && (pos_q >= acss_pkg::SPEEX_MIN_POS);
		hit_any    = opus_hit || theora_hit || oflac_hit || speex_hit;
		if (opus_hit) begin
			hit_kind  = acss_pkg::DET_OPUS;
			hit_start = pos_q - acss_pkg::pos_t'(7);
		end else if (theora_hit) begin
			hit_kind  = acss_pkg::DET_THEORA;
			hit_start = pos_q - acss_pkg::pos_t'(6);
		end else if (oflac_hit) begin
			hit_kind  = acss_pkg::DET_OGG_FLAC;
			hit_start = pos_q - acss_pkg::pos_t'(4);
		end else begin
			hit_kind  = acss_pkg::DET_SPEEX;
			hit_start = pos_q - acss_pkg::pos_t'(7);
		end
		// A shorter pattern found earlier may start later than a longer one found now.
		take       = hit_any && (hit_start < start_q);
		kind_next  = take ? hit_kind : kind_q;
		start_next = take ? hit_start : start_q;
		vorbis_next = vorbis_q || ((win_next[55:0] == acss_pkg::PAT_VORBIS)
			&& (pos_q >= acss_pkg::VORBIS_MIN_POS));
	end

	// The signature must start at least eight bytes before the last byte of the blob.
	assign late_ok = ({1'b0, start_next} + 33'd8) <= {1'b0, pos_q};

	always_comb begin
		fmt_c = acss_pkg::FMT_UNKNOWN;
		det_c = acss_pkg::DET_NONE;
		if (pos_q >= acss_pkg::pos_t'(11)
				&& {hdr_next[0], hdr_next[1], hdr_next[2], hdr_next[3]} == acss_pkg::PAT_RIFF
				&& {hdr_next[8], hdr_next[9], hdr_next[10], hdr_next[11]}
					== acss_pkg::PAT_WAVE) begin
			fmt_c = acss_pkg::FMT_WAV;
		end else if (pos_q >= acss_pkg::pos_t'(3)
				&& {hdr_next[0], hdr_next[1], hdr_next[2], hdr_next[3]}
					== acss_pkg::PAT_FLAC) begin
			fmt_c = acss_pkg::FMT_FLAC;
		end else if (pos_q >= acss_pkg::pos_t'(2)
				&& ({hdr_next[0], hdr_next[1], hdr_next[2]} == acss_pkg::PAT_ID3
				|| (hdr_next[0] == acss_pkg::MP3_SYNC
				&& (hdr_next[1] & acss_pkg::MP3_MASK) == acss_pkg::MP3_MASK))) begin
			fmt_c = acss_pkg::FMT_MP3;
		end else if (pos_q >= acss_pkg::pos_t'(3)
				&& {hdr_next[0], hdr_next[1], hdr_next[2], hdr_next[3]}
					== acss_pkg::PAT_OGGS) begin
			if (vorbis_next) begin
				fmt_c = acss_pkg::FMT_OGG_VORBIS;
			end else if (kind_next != acss_pkg::DET_NONE && late_ok) begin
				det_c = kind_next;
			end else begin
				det_c = acss_pkg::DET_UNRECOGNIZED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			byte_s1 <= item.data_byte;
			last_s1 <= item.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			vorbis_q <= 1'b0;
			kind_q   <= acss_pkg::DET_NONE;
			start_q  <= acss_pkg::POS_MAX;
		end else if (advance) begin
			if (last_s1) begin
				pos_q    <= '0;
				vorbis_q <= 1'b0;
				kind_q   <= acss_pkg::DET_NONE;
				start_q  <= acss_pkg::POS_MAX;
			end else begin
				pos_q    <= (pos_q == acss_pkg::POS_MAX) ? pos_q : pos_q + 1'b1;
				vorbis_q <= vorbis_next;
				kind_q   <= kind_next;
				start_q  <= start_next;
			end
		end
	end

	// Header and window contents are only read once the position guards cover them.
	always_ff @(posedge clk) begin
		if (advance) begin
			win_q <= win_next[55:0];
			for (int i = 0; i < acss_pkg::HDR_LEN; i++) begin
				hdr_q[i] <= hdr_next[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			result_q.format_code <= fmt_c;
			result_q.ogg_detail  <= det_c;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[rtl/core/acss_checker.sv]
// Port-level checker of the container signature sniffer and its bind.
`include "audio_container_signature_sniffer_defines.svh"

module acss_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input acss_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_ready,
	input acss_pkg::result_t result
);

	// A held result word must not change or vanish while the receiver stalls.
	`ACSS_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "result word changed while stalled")

	// Input is only refused while a finished result is waiting.
	`ACSS_ASSERT_IMP(a_ready_only_stalled, !item_ready, result_valid && !result_ready, "item channel stalled without a held result")

	// An accepted last byte must be followed by a valid result word.
	`ACSS_ASSERT_IMP(a_last_gives_result, item_valid && item_ready && item.last_byte, ##2 result_valid, "no result after a last byte")

	// A new result appears only after a last byte was taken.
	`ACSS_ASSERT_IMP(a_result_has_cause, $rose(result_valid), $past(item_valid && item_ready && item.last_byte, 2), "result word without a last byte")

endmodule

bind audio_container_signature_sniffer acss_checker u_acss_checker (.*);
